/* design/nwte_pkg.sv */
`timescale 1ns / 1ps

package nwte_pkg;

	localparam int IF_W          = 27;
	localparam int CLK_W         = 27;
	localparam int FREQ_W        = 23;
	localparam int TPS_W         = 24;
	localparam int WORD_BITS_DEF = 23;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CLK_W-1:0] ADC_CLOCK_RST = 27'd28800000;

	localparam logic [CFG_IDX_W-1:0] REG_ADC_CLOCK    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPECTRUM_INV = 1'b1;

	localparam logic [1:0] BW_NONE = 2'd3;

	localparam logic [1:0] FFT_2K      = 2'd0;
	localparam logic [1:0] FFT_8K      = 2'd1;
	localparam logic [2:0] GUARD_MAX   = 3'd3;
	localparam logic [2:0] HIER_MAX    = 3'd3;
	localparam logic [2:0] CONST_MAX   = 3'd2;
	localparam logic [2:0] RATE_MAX    = 3'd4;
	localparam logic [2:0] RATE_NONE   = 3'd7;

	typedef struct packed {
		logic [IF_W-1:0] if_freq_hz;
		logic [1:0]      bandwidth_code;
		logic [1:0]      fft_mode;
		logic [2:0]      guard_code;
		logic [2:0]      hierarchy_code;
		logic [2:0]      constellation_code;
		logic [2:0]      rate_high_code;
		logic [2:0]      rate_low_code;
	} tune_req_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq_word;
		logic [FREQ_W-1:0] freq_word_mirror;
		logic              freq_word_valid;
		logic [TPS_W-1:0]  tps_bits;
		logic              auto_detect;
		logic              bad_bandwidth;
	} tune_rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] addr;
		logic [CLK_W-1:0]     wdata;
	} cfg_wr_t;

endpackage

/* design/nwte_req_if.sv */
`timescale 1ns / 1ps

interface nwte_req_if;
	logic                  valid;
	logic                  ready;
	nwte_pkg::tune_req_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/nwte_rsp_if.sv */
`timescale 1ns / 1ps

interface nwte_rsp_if;
	logic                  valid;
	logic                  ready;
	nwte_pkg::tune_rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/nwte_cfg_if.sv */
`timescale 1ns / 1ps

interface nwte_cfg_if;
	logic                valid;
	logic                ready;
	nwte_pkg::cfg_wr_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/if_nco_word_and_tps_encoder.sv */
`timescale 1ns / 1ps

// Tune request encoder: turns an IF frequency into an NCO frequency word and
// packs the DVB-T transmission parameters into three TPS bytes.
// Channels: req takes one tune request per transfer, rsp gives one result per
// request, cfg writes the ADC clock (index 0) and the inversion flag (index 1);
// cfg is always ready; it is to be written only while no request is in
// flight, a rule for the user that the block itself does not enforce. When
// the word is recomputed (first tune or new bandwidth) the IF is reduced
// modulo the ADC clock one bit per cycle, folded in the fold state and
// divided by the clock one quotient bit per cycle into a WORD_BITS-bit word.
// Other requests, including an unsupported bandwidth, go from idle straight
// to the done state and on into the output register. One request is worked
// on at a time; the next one is taken as soon as the result sits in the output
// register, even while the receiver stalls it. A stalled result holds until it
// is taken and the block then waits with req not ready.
// Reset sets the clock to 28.8 MHz, clears inversion and marks the next tune
// as the first one.
module if_nco_word_and_tps_encoder #(
	parameter int WORD_BITS = nwte_pkg::WORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nwte_req_if.sink   req,
	nwte_rsp_if.source rsp,
	nwte_cfg_if.sink   cfg
);
	import nwte_pkg::*;

	localparam int CNT_MAX = (IF_W > WORD_BITS) ? IF_W : WORD_BITS;
	localparam int CNT_W   = $clog2(CNT_MAX);
	localparam int EXT_W   = (WORD_BITS > FREQ_W) ? WORD_BITS : FREQ_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CLK_W-1:0]     adc_clk_q;
	logic                 spectrum_inv_q;
	logic [1:0]           last_bw_q;
	logic                 first_q;
	logic                 rsp_valid_q;
	tune_rsp_t            rsp_q;

	logic [IF_W-1:0]      f_sh_q;
	logic [CLK_W-1:0]     rem_q;
	logic [WORD_BITS-1:0] quo_q;
	logic                 neg_q;
	logic                 zero_q;
	logic                 bad_q;
	logic                 recomp_q;
	logic [TPS_W-1:0]     tps_q;
	logic                 auto_q;

	logic                 req_fire;
	logic                 rsp_load;
	logic                 recomp;
	logic [CLK_W:0]       trial;
	logic [CLK_W:0]       diff;
	logic                 fits;
	logic [7:0]           byte0;
	logic [7:0]           byte1;
	logic [7:0]           byte2;
	logic                 autom;
	logic [WORD_BITS-1:0] quo_eff;
	logic [WORD_BITS-1:0] quo_neg;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mirror;
	logic [EXT_W-1:0]     word_ext;
	logic [EXT_W-1:0]     mirror_ext;
	logic                 inv;
	tune_rsp_t            result;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign recomp = (req.data.bandwidth_code != last_bw_q) || first_q;

	// Shared restoring step: the modulo shifts in IF bits, the division zeros.
	always_comb begin
		if (state_q == ST_MOD) begin
			trial = {rem_q, f_sh_q[IF_W-1]};
		end else begin
			trial = {rem_q, 1'b0};
		end
		diff = trial - {1'b0, adc_clk_q};
		fits = (trial >= {1'b0, adc_clk_q});
	end

	always_comb begin
		byte0 = 8'd0;
		byte1 = 8'h10;
		byte2 = 8'd0;
		autom = 1'b0;
		if (req.data.fft_mode == FFT_8K) begin
			byte0[0] = 1'b1;
		end else if (req.data.fft_mode != FFT_2K) begin
			autom = 1'b1;
		end
		if (req.data.guard_code <= GUARD_MAX) begin
			byte0[3:2] = req.data.guard_code[1:0];
		end else begin
			autom = 1'b1;
		end
		if (req.data.hierarchy_code <= HIER_MAX) begin
			byte0[5:4] = req.data.hierarchy_code[1:0];
		end else begin
			autom = 1'b1;
		end
		byte1[3:2] = req.data.bandwidth_code;
		if (req.data.constellation_code <= CONST_MAX) begin
			byte1[7:6] = req.data.constellation_code[1:0];
		end else begin
			autom = 1'b1;
		end
		if (req.data.rate_high_code <= RATE_MAX) begin
			byte2[2:0] = req.data.rate_high_code;
		end else begin
			autom = 1'b1;
		end
		if (req.data.rate_low_code <= RATE_MAX) begin
			byte2[5:3] = req.data.rate_low_code;
		end else if (req.data.rate_low_code != RATE_NONE) begin
			autom = 1'b1;
		end
	end

	// The stored word and its mirror are the quotient and its negation,
	// swapped when inversion applies.
	always_comb begin
		quo_eff    = zero_q ? '0 : quo_q;
		quo_neg    = '0 - quo_eff;
		inv        = ~(neg_q ^ spectrum_inv_q);
		word       = inv ? quo_neg : quo_eff;
		mirror     = inv ? quo_eff : quo_neg;
		word_ext   = EXT_W'(word);
		mirror_ext = EXT_W'(mirror);
		result     = '0;
		if (bad_q) begin
			result.bad_bandwidth = 1'b1;
		end else begin
			result.tps_bits    = tps_q;
			result.auto_detect = auto_q;
			if (recomp_q) begin
				result.freq_word        = word_ext[FREQ_W-1:0];
				result.freq_word_mirror = mirror_ext[FREQ_W-1:0];
				result.freq_word_valid  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			adc_clk_q      <= ADC_CLOCK_RST;
			spectrum_inv_q <= 1'b0;
			last_bw_q      <= BW_NONE;
			first_q        <= 1'b1;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.data.addr)
					REG_ADC_CLOCK:    adc_clk_q      <= cfg.data.wdata;
					REG_SPECTRUM_INV: spectrum_inv_q <= cfg.data.wdata[0];
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.data.bandwidth_code != BW_NONE) begin
							last_bw_q <= req.data.bandwidth_code;
							first_q   <= 1'b0;
						end
						if (req.data.bandwidth_code != BW_NONE && recomp) begin
							cnt_q   <= CNT_W'(IF_W - 1);
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MOD: begin
					if (cnt_q == '0) begin
						state_q <= ST_FOLD;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_FOLD: begin
					cnt_q   <= CNT_W'(WORD_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					f_sh_q   <= req.data.if_freq_hz;
					rem_q    <= '0;
					bad_q    <= (req.data.bandwidth_code == BW_NONE);
					recomp_q <= recomp;
					tps_q    <= {byte2, byte1, byte0};
					auto_q   <= autom;
				end
			end
			ST_MOD: begin
				f_sh_q <= {f_sh_q[IF_W-2:0], 1'b0};
				rem_q  <= fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
			end
			ST_FOLD: begin
				if (adc_clk_q == '0) begin
					zero_q <= 1'b1;
					neg_q  <= 1'b0;
					rem_q  <= '0;
				end else if (rem_q > (adc_clk_q >> 1)) begin
					zero_q <= 1'b0;
					neg_q  <= 1'b1;
					rem_q  <= adc_clk_q - rem_q;
				end else begin
					zero_q <= 1'b0;
					neg_q  <= 1'b0;
				end
			end
			ST_DIV: begin
				quo_q <= {quo_q[WORD_BITS-2:0], fits};
				rem_q <= fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_q <= result;
				end
			end
			default: ;
		endcase
	end

endmodule

/* test/tb_if_nco_word_and_tps_encoder.sv */
`timescale 1ns / 1ps

module tb_if_nco_word_and_tps_encoder;
	import nwte_pkg::*;

	localparam int WB          = WORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 70;

	localparam int         TPS_HP_SEL = 4;

	typedef enum logic {ROW_CFG, ROW_TUNE} row_kind_e;

	typedef struct {
		row_kind_e kind;
		cfg_wr_t   wr;
		tune_req_t tune;
		logic      typed;
		tune_rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	nwte_req_if req();
	nwte_rsp_if rsp();
	nwte_cfg_if cfg();

	if_nco_word_and_tps_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Local copy of the block's registers and tuning state.
	logic [CLK_W-1:0] adc_clock    = ADC_CLOCK_RST;
	logic             spectrum_inv = 1'b0;
	logic [1:0]       stored_bw    = BW_NONE;
	logic             tune_pending = 1'b1;

	tune_rsp_t expected_results[$];
	dir_row_t  directed_rows[$];

	logic calm = 1'b0;
	int   cycle_count      = 0;
	int   sent_count       = 0;
	int   checked_count    = 0;
	int   recomputed_count = 0;
	int   bad_bw_count     = 0;
	int   mismatches       = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_if_nco_word_and_tps_encoder: FAIL");
			$finish;
		end
	end

	function automatic tune_rsp_t predict_tune(input tune_req_t r);
		tune_rsp_t       o;
		longint unsigned f, clk_hz, half, k, sub, mag, q, full, mirror;
		logic            neg, inv, any_auto;
		logic [7:0]      b0, b1, b2;
		o = '0;
		if (r.bandwidth_code == BW_NONE) begin
			o.bad_bandwidth = 1'b1;
			return o;
		end
		if (r.bandwidth_code != stored_bw || tune_pending) begin
			full   = 64'd1 << WB;
			clk_hz = 64'(adc_clock);
			f      = 64'(r.if_freq_hz);
			mag    = '0;
			q      = '0;
			neg    = 1'b0;
			if (clk_hz != 0) begin
				// Fold the IF into the band of plus or minus half the sampling clock.
				half = clk_hz / 2;
				mag  = f;
				if (f > half) begin
					k   = (f - half + clk_hz - 1) / clk_hz;
					sub = k * clk_hz;
					neg = sub > f;
					mag = neg ? sub - f : f - sub;
				end
				q = (mag << WB) / clk_hz;
			end
			inv = neg ? spectrum_inv : !spectrum_inv;
			if (inv)
				q = full - q;
			q      = q & (full - 1);
			mirror = (full - q) & (full - 1);
			o.freq_word        = q[FREQ_W-1:0];
			o.freq_word_mirror = mirror[FREQ_W-1:0];
			o.freq_word_valid  = 1'b1;
		end
		b0       = '0;
		b1       = '0;
		b2       = '0;
		any_auto = 1'b0;
		if (r.fft_mode == FFT_8K)
			b0[0] = 1'b1;
		else if (r.fft_mode != FFT_2K)
			any_auto = 1'b1;
		if (r.guard_code <= GUARD_MAX)
			b0[3:2] = r.guard_code[1:0];
		else
			any_auto = 1'b1;
		if (r.hierarchy_code <= HIER_MAX)
			b0[5:4] = r.hierarchy_code[1:0];
		else
			any_auto = 1'b1;
		b1[TPS_HP_SEL] = 1'b1;
		b1[3:2]        = r.bandwidth_code;
		if (r.constellation_code <= CONST_MAX)
			b1[7:6] = r.constellation_code[1:0];
		else
			any_auto = 1'b1;
		if (r.rate_high_code <= RATE_MAX)
			b2[2:0] = r.rate_high_code;
		else
			any_auto = 1'b1;
		if (r.rate_low_code <= RATE_MAX)
			b2[5:3] = r.rate_low_code;
		else if (r.rate_low_code != RATE_NONE)
			any_auto = 1'b1;
		stored_bw     = r.bandwidth_code;
		tune_pending  = 1'b0;
		o.tps_bits    = {b2, b1, b0};
		o.auto_detect = any_auto;
		return o;
	endfunction

	function automatic dir_row_t tune_row(input logic [IF_W-1:0] f, input logic [1:0] bw,
			input logic [1:0] fft, input logic [2:0] gi, input logic [2:0] hi,
			input logic [2:0] con, input logic [2:0] rh, input logic [2:0] rl,
			input logic typed, input tune_rsp_t want);
		dir_row_t row;
		row.kind  = ROW_TUNE;
		row.wr    = '0;
		row.tune  = '{f, bw, fft, gi, hi, con, rh, rl};
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] addr,
			input logic [CLK_W-1:0] value);
		dir_row_t row;
		row.kind  = ROW_CFG;
		row.wr    = '{addr, value};
		row.tune  = '0;
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic tune_req_t rand_tune();
		tune_req_t       r;
		longint unsigned near;
		int              pick;
		r.if_freq_hz         = IF_W'($urandom());
		r.fft_mode           = 2'($urandom());
		r.guard_code         = 3'($urandom());
		r.hierarchy_code     = 3'($urandom());
		r.constellation_code = 3'($urandom());
		r.rate_high_code     = 3'($urandom());
		r.rate_low_code      = 3'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 15)
			r.bandwidth_code = BW_NONE;
		else if (pick < 55 && stored_bw != BW_NONE)
			r.bandwidth_code = stored_bw;
		else
			r.bandwidth_code = 2'($urandom_range(0, 2));
		// A quarter of the frequencies sit close to a multiple of half the clock.
		if ($urandom_range(0, 3) == 0) begin
			near = longint'(adc_clock / 2) * $urandom_range(0, 8) + $urandom_range(0, 4);
			near = near - 2;
			r.if_freq_hz = near[IF_W-1:0];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		tune_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no tune request outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("freq_word", 64'(want.freq_word), 64'(rsp.data.freq_word));
				check_field("freq_word_mirror", 64'(want.freq_word_mirror),
					64'(rsp.data.freq_word_mirror));
				check_field("freq_word_valid", 64'(want.freq_word_valid),
					64'(rsp.data.freq_word_valid));
				check_field("tps_bits", 64'(want.tps_bits), 64'(rsp.data.tps_bits));
				check_field("auto_detect", 64'(want.auto_detect),
					64'(rsp.data.auto_detect));
				check_field("bad_bandwidth", 64'(want.bad_bandwidth),
					64'(rsp.data.bad_bandwidth));
				checked_count++;
				if (rsp.data.freq_word_valid)
					recomputed_count++;
				if (rsp.data.bad_bandwidth)
					bad_bw_count++;
			end
		end
	end

	always @(posedge clk)
		rsp.ready <= calm || ($urandom_range(0, 99) >= 12);

	task automatic send_tune(input tune_req_t r, input logic typed, input tune_rsp_t want);
		tune_rsp_t pred;
		while (!calm && $urandom_range(0, 99) < 12) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		do
			@(posedge clk);
		while (!req.ready);
		pred = predict_tune(r);
		expected_results.push_back(typed ? want : pred);
		sent_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CLK_W-1:0] value);
		cfg.valid      <= 1'b1;
		cfg.data.addr  <= addr;
		cfg.data.wdata <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		if (addr == REG_ADC_CLOCK)
			adc_clock = value;
		else
			spectrum_inv = value[0];
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers are only written once every outstanding result has come back.
	task automatic drain();
		req.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [CLK_W-1:0] clock_hz;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		cfg.valid = 1'b0;
		cfg.data  = '0;
		rsp.ready = 1'b0;

		// The first tune with a zero IF gives an inverted zero word, masked to zero.
		directed_rows.push_back(tune_row(27'd0, 2'd0, FFT_2K, 3'd0, 3'd0, 3'd0, 3'd0,
			3'd0, 1'b1, tune_rsp_t'{23'd0, 23'd0, 1'b1, 24'h001000, 1'b0, 1'b0}));
		directed_rows.push_back(tune_row(27'h7FFFFFF, BW_NONE, 2'd3, 3'd7, 3'd7, 3'd7,
			3'd7, 3'd7, 1'b1, tune_rsp_t'{23'd0, 23'd0, 1'b0, 24'h0, 1'b0, 1'b1}));
		directed_rows.push_back(tune_row(27'd12345, 2'd0, 2'd3, 3'd5, 3'd5, 3'd4, 3'd6,
			3'd6, 1'b1, tune_rsp_t'{23'd0, 23'd0, 1'b0, 24'h001000, 1'b1, 1'b0}));
		directed_rows.push_back(tune_row(27'd12345, 2'd0, FFT_8K, GUARD_MAX, HIER_MAX,
			CONST_MAX, RATE_MAX, RATE_NONE, 1'b1,
			tune_rsp_t'{23'd0, 23'd0, 1'b0, 24'h04903D, 1'b0, 1'b0}));
		directed_rows.push_back(tune_row(27'd36125000, 2'd1, 2'd0, 3'd1, 3'd2, 3'd1, 3'd1,
			3'd3, 1'b0, '0));
		directed_rows.push_back(tune_row(27'h7FFFFFF, 2'd2, 2'd1, 3'd2, 3'd1, 3'd0, 3'd2,
			3'd4, 1'b0, '0));
		directed_rows.push_back(tune_row(27'd14400000, 2'd0, 2'd0, 3'd0, 3'd0, 3'd0, 3'd0,
			3'd5, 1'b0, '0));
		directed_rows.push_back(tune_row(27'd14400001, 2'd1, 2'd1, 3'd1, 3'd1, 3'd1, 3'd3,
			3'd7, 1'b0, '0));
		directed_rows.push_back(tune_row(27'd28800000, 2'd2, 2'd2, 3'd6, 3'd6, 3'd3, 3'd5,
			3'd0, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_SPECTRUM_INV, 27'd1));
		directed_rows.push_back(tune_row(27'd5000000, 2'd0, 2'd1, 3'd3, 3'd0, 3'd2, 3'd4,
			3'd1, 1'b0, '0));
		directed_rows.push_back(tune_row(27'd20000000, 2'd1, 2'd0, 3'd2, 3'd3, 3'd0, 3'd0,
			3'd2, 1'b0, '0));
		// With a zero clock the word is forced to zero.
		directed_rows.push_back(cfg_row(REG_ADC_CLOCK, 27'd0));
		directed_rows.push_back(tune_row(27'd12345678, 2'd2, FFT_2K, 3'd0, 3'd0, 3'd0, 3'd0,
			3'd0, 1'b1, tune_rsp_t'{23'd0, 23'd0, 1'b1, 24'h001800, 1'b0, 1'b0}));
		directed_rows.push_back(cfg_row(REG_SPECTRUM_INV, 27'd0));
		directed_rows.push_back(tune_row(27'd777, 2'd0, FFT_2K, 3'd0, 3'd0, 3'd0, 3'd0,
			3'd0, 1'b1, tune_rsp_t'{23'd0, 23'd0, 1'b1, 24'h001000, 1'b0, 1'b0}));
		directed_rows.push_back(cfg_row(REG_ADC_CLOCK, 27'h7FFFFFF));
		directed_rows.push_back(tune_row(27'h7FFFFFF, 2'd1, 2'd1, 3'd1, 3'd2, 3'd1, 3'd1,
			3'd1, 1'b0, '0));
		directed_rows.push_back(tune_row(27'h4000000, 2'd2, 2'd0, 3'd0, 3'd1, 3'd2, 3'd3,
			3'd4, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_ADC_CLOCK, 27'd1));
		directed_rows.push_back(tune_row(27'd5, 2'd0, 2'd1, 3'd3, 3'd3, 3'd2, 3'd4,
			3'd7, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_ADC_CLOCK, 27'd1000000));
		directed_rows.push_back(tune_row(27'd500001, 2'd1, 2'd0, 3'd2, 3'd0, 3'd1, 3'd2,
			3'd3, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_ADC_CLOCK, 27'd100000000));
		directed_rows.push_back(tune_row(27'd60000000, 2'd2, 2'd1, 3'd1, 3'd1, 3'd0, 3'd1,
			3'd2, 1'b0, '0));
		directed_rows.push_back(tune_row(27'd60000000, 2'd2, 2'd0, 3'd4, 3'd7, 3'd5, 3'd7,
			3'd0, 1'b0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed_rows[i].wr.addr, directed_rows[i].wr.wdata);
			end else begin
				send_tune(directed_rows[i].tune, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0: clock_hz = '0;
				1: clock_hz = '1;
				2: clock_hz = CLK_W'($urandom_range(1, 1000));
				default: clock_hz = CLK_W'($urandom_range(1000000, 100000000));
			endcase
			if (phase == 0)
				clock_hz = ADC_CLOCK_RST;
			drain();
			write_reg(REG_ADC_CLOCK, clock_hz);
			write_reg(REG_SPECTRUM_INV, CLK_W'($urandom_range(0, 1)));
			calm = (phase == PHASES / 2);
			repeat (PHASE_ITEMS) send_tune(rand_tune(), 1'b0, '0);
		end

		drain();
		repeat (60) @(posedge clk);

		$display("Sent %0d tune requests over %0d random clock and inversion settings.",
			sent_count, PHASES);
		$display("Checked %0d results: %0d with a new NCO word, %0d unsupported bandwidths.",
			checked_count, recomputed_count, bad_bw_count);
		if (mismatches == 0)
			$display("tb_if_nco_word_and_tps_encoder: PASS");
		else
			$display("tb_if_nco_word_and_tps_encoder: FAIL");
		$finish;
	end

endmodule

/* if_nco_word_and_tps_encoder.f */
design/nwte_pkg.sv
design/nwte_req_if.sv
design/nwte_rsp_if.sv
design/nwte_cfg_if.sv
design/if_nco_word_and_tps_encoder.sv
test/tb_if_nco_word_and_tps_encoder.sv
